[rtl/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the sand cell update engine.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;

  // coordinate width: holds -1 (as all ones) and up to the largest grid plus one
  localparam int CW = 11;

  typedef logic [CW-1:0] coord_t;
  typedef logic [1:0]    mat_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  localparam mat_t MAT_AIR   = 2'd0;
  localparam mat_t MAT_SAND  = 2'd1;
  localparam mat_t MAT_WATER = 2'd2;
  localparam mat_t MAT_STONE = 2'd3;

endpackage

[rtl/fsc_req_if.sv]
// ----------------------------------------------------------------------------
// fsc_req_if
// Request channel: operation, cell address, material and random choice.
// ----------------------------------------------------------------------------
interface fsc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] cell_x;
  logic [7:0] cell_y;
  logic [1:0] material_in;
  logic       random_bit;

  modport source (output valid, operation, cell_x, cell_y, material_in, random_bit,
                  input ready);
  modport sink   (input valid, operation, cell_x, cell_y, material_in, random_bit,
                  output ready);
endinterface

[rtl/fsc_rsp_if.sv]
// ----------------------------------------------------------------------------
// fsc_rsp_if
// Result channel: reported cell position, material, change and last flags.
// ----------------------------------------------------------------------------
interface fsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [1:0] material_out;
  logic       changed;
  logic       last;

  modport source (output valid, pos_x, pos_y, material_out, changed, last, input ready);
  modport sink   (input valid, pos_x, pos_y, material_out, changed, last, output ready);
endinterface

[rtl/fsc_ram.sv]
// ----------------------------------------------------------------------------
// fsc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/falling_sand_cell_update.sv]
// ----------------------------------------------------------------------------
// falling_sand_cell_update
// Sand and water cell rules over a current and a next grid held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | accepted when
//  req     | in  | operation cell_x cell_y material_in random_bit | valid && ready
//  rsp     | out | pos_x pos_y material_out changed last           | valid && ready
//
// Write stores to both grids on acceptance; read reports the cell. Update reads
// the own cell, looks up to 5 neighbors, makes up to 3 writes and then reports
// the moved cells one by one. A result still waiting in the output register
// delays each report and the read. Commit copies the next grid into the current
// grid, one cell per cycle through the RAM ports. After reset a clearing pass
// zeroes both grids; req is held off meanwhile. A held result does not block
// accepting the next request.
// ----------------------------------------------------------------------------
module falling_sand_cell_update
  import fsc_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fsc_req_if.sink   req,
  fsc_rsp_if.source rsp
);

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CLEAR = 11'b000_0000_0010,
    ST_COPY  = 11'b000_0000_0100,
    ST_LOOK  = 11'b000_0000_1000,
    ST_RDD   = 11'b000_0001_0000,
    ST_CAND  = 11'b000_0010_0000,
    ST_CANDD = 11'b000_0100_0000,
    ST_PUSH  = 11'b000_1000_0000,
    ST_PUSHD = 11'b001_0000_0000,
    ST_WR    = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  function automatic logic in_grid(coord_t cx, coord_t cy);
    return (cx < CW'(GRID_WIDTH)) && (cy < CW'(GRID_HEIGHT));
  endfunction

  function automatic addr_t cell_addr(coord_t cx, coord_t cy);
    return {cy[YW-1:0], cx[XW-1:0]};
  endfunction

  state_t      state;
  logic [AW:0] cnt;
  logic [7:0]  sx, sy;
  logic        rb, is_water, rd_in;
  logic [1:0]  k, pk, wc, ri;
  coord_t      tx, ty, px, py;
  mat_t        cur_s, cur_t, sval;
  logic        pushed;

  logic  n_we, n_re, c_we, c_re;
  addr_t n_waddr, n_raddr, c_waddr, c_raddr;
  mat_t  n_wdata, c_wdata, n_rdata, c_rdata;

  logic  out_free, rsp_load;
  coord_t xe, ye, cand_x, cand_y, push_x, push_y;
  logic  cand_in, push_in, cand_last;
  coord_t rep_x, rep_y;
  mat_t  rep_m;
  logic [1:0] rep_n;

  assign out_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = out_free && (state == ST_RDD || state == ST_OUT);
  assign req.ready = (state == ST_IDLE);

  assign xe = {{(CW-8){1'b0}}, sx};
  assign ye = {{(CW-8){1'b0}}, sy};

  always_comb begin
    if (k == 2'd0) begin
      cand_x = xe;
    end else begin
      cand_x = rb ? xe + CW'(1) : xe - CW'(1);
    end
    cand_y    = (k == 2'd2) ? ye : ye + CW'(1);
    cand_in   = in_grid(cand_x, cand_y);
    cand_last = is_water ? (k == 2'd2) : (k == 2'd1);
    case (pk)
      2'd0:    begin push_x = tx - CW'(1); push_y = ty;          end
      2'd1:    begin push_x = tx + CW'(1); push_y = ty;          end
      default: begin push_x = tx;          push_y = ty + CW'(1); end
    endcase
    push_in = in_grid(push_x, push_y);
  end

  // report list: with push T,P,S,T else S,T
  always_comb begin
    rep_n = pushed ? 2'd3 : 2'd1;
    rep_x = tx;
    rep_y = ty;
    rep_m = cur_s;
    if (pushed) begin
      case (ri)
        2'd1:    begin rep_x = px; rep_y = py; rep_m = cur_t; end
        2'd2:    begin rep_x = xe; rep_y = ye; rep_m = sval;  end
        default: ;
      endcase
    end else if (ri == 2'd0) begin
      rep_x = xe;
      rep_y = ye;
      rep_m = sval;
    end
  end

  always_comb begin
    n_we = 1'b0; n_waddr = '0; n_wdata = MAT_AIR;
    c_we = 1'b0; c_waddr = '0; c_wdata = MAT_AIR;
    n_re = 1'b0; n_raddr = '0;
    c_re = 1'b0; c_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        n_we = 1'b1; n_waddr = cnt[AW-1:0];
        c_we = 1'b1; c_waddr = cnt[AW-1:0];
      end
      ST_COPY: begin
        n_re    = 1'b1;
        n_raddr = cnt[AW-1:0];
        c_we    = (cnt != '0);
        c_waddr = AW'(cnt - (AW+1)'(1));
        c_wdata = n_rdata;
      end
      ST_IDLE: begin
        if (req.valid) begin
          c_raddr = cell_addr({{(CW-8){1'b0}}, req.cell_x}, {{(CW-8){1'b0}}, req.cell_y});
          n_waddr = c_raddr;
          c_waddr = c_raddr;
          n_wdata = req.material_in;
          c_wdata = req.material_in;
          if (in_grid({{(CW-8){1'b0}}, req.cell_x}, {{(CW-8){1'b0}}, req.cell_y})) begin
            case (req.operation) inside
              OP_WRITE:           begin n_we = 1'b1; c_we = 1'b1; end
              OP_READ, OP_UPDATE: c_re = 1'b1;
              default: ;
            endcase
          end
        end
      end
      ST_CAND: begin
        n_raddr = cell_addr(cand_x, cand_y);
        c_raddr = n_raddr;
        n_re    = cand_in;
        c_re    = cand_in;
      end
      ST_PUSH: begin
        n_raddr = cell_addr(push_x, push_y);
        n_re    = push_in;
      end
      ST_WR: begin
        n_we = 1'b1;
        case (wc)
          2'd0:    begin n_waddr = cell_addr(xe, ye); n_wdata = sval;  end
          2'd1:    begin n_waddr = cell_addr(tx, ty); n_wdata = cur_s; end
          default: begin n_waddr = cell_addr(px, py); n_wdata = cur_t; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + (AW+1)'(1);
          if (cnt == (AW+1)'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_COPY: begin
          cnt <= cnt + (AW+1)'(1);
          if (cnt == (AW+1)'(DEPTH)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            sx    <= req.cell_x;
            sy    <= req.cell_y;
            rb    <= req.random_bit;
            rd_in <= c_re;
            case (req.operation)
              OP_READ:   state <= ST_RDD;
              OP_UPDATE: if (c_re) state <= ST_LOOK;
              OP_COMMIT: begin
                cnt   <= '0;
                state <= ST_COPY;
              end
              default: ;
            endcase
          end
        end
        ST_RDD: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.pos_x        <= sx;
            rsp.pos_y        <= sy;
            rsp.material_out <= rd_in ? c_rdata : MAT_AIR;
            rsp.changed      <= 1'b0;
            rsp.last         <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        ST_LOOK: begin
          cur_s    <= c_rdata;
          k        <= 2'd0;
          is_water <= (c_rdata == MAT_WATER);
          if (c_rdata == MAT_SAND || c_rdata == MAT_WATER) begin
            state <= ST_CAND;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CAND: begin
          tx <= cand_x;
          ty <= cand_y;
          if (cand_in) begin
            state <= ST_CANDD;
          end else if (cand_last) begin
            state <= ST_IDLE;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_CANDD: begin
          if (n_rdata == MAT_AIR) begin
            sval   <= MAT_AIR;
            pushed <= 1'b0;
            wc     <= 2'd0;
            state  <= ST_WR;
          end else if (!is_water && n_rdata == MAT_WATER) begin
            cur_t <= c_rdata;
            pk    <= 2'd0;
            state <= ST_PUSH;
          end else if (cand_last) begin
            state <= ST_IDLE;
          end else begin
            k     <= k + 2'd1;
            state <= ST_CAND;
          end
        end
        ST_PUSH: begin
          px <= push_x;
          py <= push_y;
          if (push_in) begin
            state <= ST_PUSHD;
          end else if (pk == 2'd2) begin
            sval   <= MAT_WATER;
            pushed <= 1'b0;
            wc     <= 2'd0;
            state  <= ST_WR;
          end else begin
            pk <= pk + 2'd1;
          end
        end
        ST_PUSHD: begin
          if (n_rdata == MAT_AIR) begin
            sval   <= MAT_AIR;
            pushed <= 1'b1;
            wc     <= 2'd0;
            state  <= ST_WR;
          end else if (pk == 2'd2) begin
            sval   <= MAT_WATER;
            pushed <= 1'b0;
            wc     <= 2'd0;
            state  <= ST_WR;
          end else begin
            pk    <= pk + 2'd1;
            state <= ST_PUSH;
          end
        end
        ST_WR: begin
          wc <= wc + 2'd1;
          if ((wc == 2'd1 && !pushed) || wc == 2'd2) begin
            ri    <= 2'd0;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.pos_x        <= rep_x[7:0];
            rsp.pos_y        <= rep_y[7:0];
            rsp.material_out <= rep_m;
            rsp.changed      <= 1'b1;
            rsp.last         <= (ri == rep_n);
            ri               <= ri + 2'd1;
            if (ri == rep_n) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  fsc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  fsc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cur_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

endmodule

[verif/tb_falling_sand_cell_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_falling_sand_cell_update
// Self-checking bench for the sand and water cell update engine. Sends
// write, read, update and commit requests with random gaps. It predicts every
// reported cell from its own copy of both grids and compares each result
// field by field, in order, while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_falling_sand_cell_update;
  import fsc_pkg::*;

  localparam int GW = 256;
  localparam int GH = 256;

  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    mat_t       material;
    logic       changed;
    logic       last;
  } cell_report_t;

  logic clk;
  logic rst;

  fsc_req_if req ();
  fsc_rsp_if rsp ();

  falling_sand_cell_update uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  mat_t         cur_grid [GW*GH];
  mat_t         nxt_grid [GW*GH];
  cell_report_t pending_reports[$];
  int           moved_x [4];
  int           moved_y [4];
  int           moved_n;
  int           errors;
  bit           calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int cell_index(int x, int y);
    return y * GW + x;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < GW && y < GH;
  endfunction

  function automatic bit empty_at(int x, int y);
    return on_grid(x, y) && nxt_grid[cell_index(x, y)] == MAT_AIR;
  endfunction

  function automatic void swap_cell(int sx, int sy, int tx, int ty);
    int s;
    int t;
    s = cell_index(sx, sy);
    t = cell_index(tx, ty);
    nxt_grid[s] = nxt_grid[t];
    nxt_grid[t] = cur_grid[s];
    moved_x[moved_n] = sx;
    moved_y[moved_n] = sy;
    moved_x[moved_n+1] = tx;
    moved_y[moved_n+1] = ty;
    moved_n += 2;
  endfunction

  function automatic bit sand_enter(int x, int y, int tx, int ty);
    mat_t m;
    m = nxt_grid[cell_index(tx, ty)];
    if (m == MAT_AIR) begin
      swap_cell(x, y, tx, ty);
      return 1'b1;
    end
    if (m == MAT_WATER) begin
      if (empty_at(tx - 1, ty)) swap_cell(tx, ty, tx - 1, ty);
      else if (empty_at(tx + 1, ty)) swap_cell(tx, ty, tx + 1, ty);
      else if (empty_at(tx, ty + 1)) swap_cell(tx, ty, tx, ty + 1);
      swap_cell(x, y, tx, ty);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void step_sand(int x, int y, bit rb);
    if (on_grid(x, y + 1) && sand_enter(x, y, x, y + 1)) return;
    if (!rb && on_grid(x - 1, y + 1) && sand_enter(x, y, x - 1, y + 1)) return;
    if (rb && on_grid(x + 1, y + 1)) void'(sand_enter(x, y, x + 1, y + 1));
  endfunction

  function automatic void step_water(int x, int y, bit rb);
    int dx;
    dx = rb ? 1 : -1;
    if (empty_at(x, y + 1)) swap_cell(x, y, x, y + 1);
    else if (empty_at(x + dx, y + 1)) swap_cell(x, y, x + dx, y + 1);
    else if (empty_at(x + dx, y)) swap_cell(x, y, x + dx, y);
  endfunction

  function automatic void nxt_grid_copy();
    for (int i = 0; i < GW*GH; i++) cur_grid[i] = nxt_grid[i];
  endfunction

  function automatic void predict_request(op_t op, int x, int y, mat_t mat, bit rb);
    cell_report_t r;
    case (op)
      OP_WRITE: begin
        cur_grid[cell_index(x, y)] = mat;
        nxt_grid[cell_index(x, y)] = mat;
      end
      OP_READ: begin
        r.pos_x = 8'(x);
        r.pos_y = 8'(y);
        r.material = cur_grid[cell_index(x, y)];
        r.changed = 1'b0;
        r.last = 1'b1;
        pending_reports.insert(pending_reports.size(), r);
      end
      OP_COMMIT: nxt_grid_copy();
      default: begin
        moved_n = 0;
        if (cur_grid[cell_index(x, y)] == MAT_SAND) step_sand(x, y, rb);
        else if (cur_grid[cell_index(x, y)] == MAT_WATER) step_water(x, y, rb);
        for (int k = 0; k < moved_n; k++) begin
          r.pos_x = 8'(moved_x[k]);
          r.pos_y = 8'(moved_y[k]);
          r.material = nxt_grid[cell_index(moved_x[k], moved_y[k])];
          r.changed = 1'b1;
          r.last = (k == moved_n - 1);
          pending_reports.insert(pending_reports.size(), r);
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(op_t op, int x, int y, mat_t mat, bit rb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.cell_x <= 8'(x);
    req.cell_y <= 8'(y);
    req.material_in <= mat;
    req.random_bit <= rb;
    do @(posedge clk); while (!req.ready);
    predict_request(op, x, y, mat, rb);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d mat=%0d", $time,
                   rsp.pos_x, rsp.pos_y, rsp.material_out);
          errors++;
        end else begin
          cell_report_t e;
          e = pending_reports.pop_front();
          if (rsp.pos_x !== e.pos_x || rsp.pos_y !== e.pos_y ||
              rsp.material_out !== e.material || rsp.changed !== e.changed ||
              rsp.last !== e.last) begin
            $display("%0t: mismatch expected x=%0d y=%0d mat=%0d chg=%0d last=%0d",
                     $time, e.pos_x, e.pos_y, e.material, e.changed, e.last);
            $display("%0t:          actual   x=%0d y=%0d mat=%0d chg=%0d last=%0d",
                     $time, rsp.pos_x, rsp.pos_y, rsp.material_out, rsp.changed,
                     rsp.last);
            errors++;
          end
        end
      end
      rsp.ready <= calm ? 1'b1 : (pick_gap() == 0);
    end
  end

  task automatic test_write_read();
    send_request(OP_WRITE, 255, 255, MAT_STONE, 1'b1);
    send_request(OP_WRITE, 0, 0, MAT_WATER, 1'b0);
    send_request(OP_READ, 255, 255, MAT_AIR, 1'b0);
    send_request(OP_READ, 0, 0, MAT_STONE, 1'b1);
    send_request(OP_READ, 170, 85, MAT_SAND, 1'b0);
  endtask

  task automatic test_sand();
    send_request(OP_WRITE, 10, 10, MAT_SAND, 1'b0);
    send_request(OP_UPDATE, 10, 10, MAT_AIR, 1'b0);
    send_request(OP_WRITE, 20, 20, MAT_SAND, 1'b0);
    send_request(OP_WRITE, 20, 21, MAT_WATER, 1'b0);
    send_request(OP_UPDATE, 20, 20, MAT_AIR, 1'b1);
    send_request(OP_WRITE, 0, 254, MAT_SAND, 1'b0);
    send_request(OP_WRITE, 0, 255, MAT_STONE, 1'b0);
    send_request(OP_UPDATE, 0, 254, MAT_AIR, 1'b0);
    send_request(OP_WRITE, 255, 254, MAT_SAND, 1'b0);
    send_request(OP_UPDATE, 255, 254, MAT_AIR, 1'b1);
  endtask

  task automatic test_water();
    send_request(OP_WRITE, 40, 255, MAT_WATER, 1'b0);
    send_request(OP_UPDATE, 40, 255, MAT_AIR, 1'b0);
    send_request(OP_UPDATE, 40, 255, MAT_AIR, 1'b1);
    send_request(OP_WRITE, 60, 60, MAT_STONE, 1'b0);
    send_request(OP_UPDATE, 60, 60, MAT_AIR, 1'b1);
    send_request(OP_UPDATE, 61, 60, MAT_AIR, 1'b0);
    send_request(OP_COMMIT, 0, 0, MAT_AIR, 1'b0);
    send_request(OP_READ, 40, 255, MAT_AIR, 1'b0);
    send_request(OP_READ, 20, 22, MAT_AIR, 1'b1);
  endtask

  task automatic test_random_scenes();
    int bx;
    int by;
    int n;
    n = 0;
    while (n < 405) begin
      calm = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
        0: bx = $urandom_range(0, 3);
        1: bx = $urandom_range(252, 255);
        default: bx = $urandom_range(0, 255);
      endcase
      by = ($urandom_range(0, 2) == 0) ? $urandom_range(252, 255) : $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 4; i++) begin
          send_request(op_t'($urandom_range(0, 2)), $urandom_range(0, 255),
                       $urandom_range(0, 255), mat_t'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)));
          n++;
        end
      end else begin
        for (int i = 0; i < 6; i++) begin
          send_request(OP_WRITE, (bx + $urandom_range(0, 2)) & 8'hff,
                       (by + $urandom_range(0, 2)) & 8'hff,
                       mat_t'($urandom_range(0, 3)), 1'b0);
          n++;
        end
        for (int i = 0; i < 5; i++) begin
          send_request(($urandom_range(0, 3) == 0) ? OP_READ : OP_UPDATE,
                       (bx + $urandom_range(0, 2)) & 8'hff,
                       (by + $urandom_range(0, 2)) & 8'hff,
                       mat_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
          n++;
        end
      end
      if ((n % 90) < 11) begin
        send_request(OP_COMMIT, $urandom_range(0, 255), $urandom_range(0, 255),
                     mat_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        n++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    errors = 0;
    calm = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_WRITE;
    req.cell_x <= '0;
    req.cell_y <= '0;
    req.material_in <= MAT_AIR;
    req.random_bit <= 1'b0;
    for (int i = 0; i < GW*GH; i++) begin
      cur_grid[i] = MAT_AIR;
      nxt_grid[i] = MAT_AIR;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_write_read();
    test_sand();
    test_water();
    test_random_scenes();
    req.valid <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fsc_pkg.sv
rtl/fsc_req_if.sv
rtl/fsc_rsp_if.sv
rtl/fsc_ram.sv
rtl/falling_sand_cell_update.sv
verif/tb_falling_sand_cell_update.sv
